/* src/lfp_pkg.sv */
`timescale 1ns / 1ps

package lfp_pkg;

    // Driving modes
    localparam logic [1:0] MODE_AUTO     = 2'd0;
    localparam logic [1:0] MODE_MANUAL   = 2'd1;
    localparam logic [1:0] MODE_OBSTACLE = 2'd2;
    localparam logic [1:0] MODE_SHOCK    = 2'd3;

    // Remote commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_MODE  = 2'd1;
    localparam logic [1:0] CMD_ANGLE = 2'd2;
    localparam logic [1:0] CMD_SPEED = 2'd3;

    // Obstacle avoidance phases
    localparam logic [1:0] PH_ROTATE  = 2'd0;
    localparam logic [1:0] PH_FORWARD = 2'd1;
    localparam logic [1:0] PH_TURN    = 2'd2;
    localparam logic [1:0] PH_HOLD    = 2'd3;

    // Config register indexes
    localparam logic [1:0] CFG_GAIN   = 2'd0;
    localparam logic [1:0] CFG_RECIP  = 2'd1;
    localparam logic [1:0] CFG_REJOIN = 2'd2;

    localparam logic [15:0]        GAIN_RST   = 16'd9011;
    localparam logic [15:0]        RECIP_RST  = 16'd1862;
    localparam logic signed [15:0] REJOIN_RST = -16'sd3277;

    localparam logic signed [15:0] HALF_SPEED = 16'sd8192;
    localparam logic signed [15:0] ZERO_SPEED = 16'sd0;

    typedef struct packed {
        logic              front_obstacle;
        logic              left_obstacle;
        logic              shock_seen;
        logic              line_lost;
        logic signed [15:0] line_position;
        logic [1:0]        command;
        logic signed [15:0] command_arg;
    } t_req;

    typedef struct packed {
        logic signed [15:0] speed_left;
        logic signed [15:0] speed_right;
        logic [1:0]         mode_now;
    } t_rsp;

    typedef struct packed {
        logic [15:0]        curve_gain;
        logic [15:0]        curve_gain_recip;
        logic signed [15:0] rejoin_threshold;
    } t_cfg;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic load_in;
        logic do_sq;
        logic do_mul_a;
        logic do_mul_b;
        logic do_fin;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SQ    = 5'b00010,
        ST_MUL_A = 5'b00100,
        ST_MUL_B = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

endpackage

/* src/lfp_ctrl.sv */
`timescale 1ns / 1ps

module lfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lfp_pkg::t_dp_sts  i_sts,
    output lfp_pkg::t_dp_cmd  o_cmd
);
    import lfp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.do_sq = 1'b1;
                n_state     = ST_MUL_A;
            end
            ST_MUL_A: begin
                o_cmd.do_mul_a = 1'b1;
                n_state        = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.do_mul_b = 1'b1;
                n_state        = ST_FIN;
            end
            ST_FIN: begin
                // wait until the output register can take the result
                if (!i_sts.out_busy) begin
                    o_cmd.do_fin = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_req_ready = (r_state == ST_IDLE);

endmodule

/* src/lfp_dp.sv */
`timescale 1ns / 1ps

module lfp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfp_pkg::t_dp_cmd  i_cmd,
    output lfp_pkg::t_dp_sts  o_sts,
    input  lfp_pkg::t_cfg     i_cfg,
    input  lfp_pkg::t_req     i_req,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output lfp_pkg::t_rsp     o_rsp
);
    import lfp_pkg::*;

    localparam logic [46:0] ROUND_HALF = 47'd1 << 25;
    localparam logic [20:0] SAT_LIMIT  = 21'd49152;
    localparam logic [16:0] ONE_Q14    = 17'd16384;

    // 1 - round(p / 2^26), saturated to 16 bits
    function automatic logic signed [15:0] curve_sat(input logic [46:0] p);
        logic [46:0] s;
        logic [20:0] t;
        logic [16:0] v;
        s = p + ROUND_HALF;
        t = s[46:26];
        v = ONE_Q14 - t[16:0];
        if (t > SAT_LIMIT) begin
            return 16'sh8000;
        end
        return $signed(v[15:0]);
    endfunction

    t_req               r_in;
    logic signed [15:0] r_x;
    logic [30:0]        r_sq;
    logic [46:0]        r_prod;
    logic signed [15:0] r_curve_a;
    logic [1:0]         r_mode;
    logic [1:0]         r_phase;
    logic               r_left;
    logic               r_rsp_valid;
    t_rsp               r_rsp;

    logic [1:0]         mode_pre;
    logic signed [15:0] x_sel;
    logic [15:0]        mag;
    logic [30:0]        mul_a;
    logic [15:0]        mul_b;
    logic [46:0]        prod;
    logic signed [15:0] curve_b;
    logic signed [15:0] steer_l, steer_r;
    logic [1:0]         n_mode, n_phase;
    logic signed [15:0] sl, sr;

    // mode after the command and shock tests; picks the steering source
    always_comb begin
        mode_pre = r_mode;
        if (r_in.command == CMD_MODE) begin
            if (r_in.command_arg == 16'sd0) begin
                mode_pre = MODE_AUTO;
            end else if (r_in.command_arg == 16'sd1) begin
                mode_pre = MODE_MANUAL;
            end
        end
        if (r_in.shock_seen) begin
            mode_pre = MODE_SHOCK;
        end
    end

    assign x_sel = (mode_pre == MODE_MANUAL) ? r_in.command_arg : r_in.line_position;
    assign mag   = x_sel[15] ? 16'(~x_sel + 16'sd1) : 16'(x_sel);

    // one shared multiplier: x*x, then x*x*recip, then x*x*gain
    always_comb begin
        mul_a = r_sq;
        mul_b = i_cfg.curve_gain;
        if (i_cmd.do_sq) begin
            mul_a = {15'd0, mag};
            mul_b = mag;
        end else if (i_cmd.do_mul_a) begin
            mul_b = i_cfg.curve_gain_recip;
        end
    end
    assign prod = {16'd0, mul_a} * {31'd0, mul_b};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_req;
        end
        if (i_cmd.do_sq) begin
            r_x  <= x_sel;
            r_sq <= prod[30:0];
        end
        if (i_cmd.do_mul_a || i_cmd.do_mul_b) begin
            r_prod <= prod;
        end
        if (i_cmd.do_mul_b) begin
            r_curve_a <= curve_sat(r_prod);
        end
    end

    assign curve_b = curve_sat(r_prod);
    assign steer_l = (r_x > 16'sd0) ? curve_b : r_curve_a;
    assign steer_r = (r_x > 16'sd0) ? r_curve_a : curve_b;

    // per-tick mode decision, in order: autonomous, manual, obstacle
    always_comb begin
        n_mode  = mode_pre;
        n_phase = r_phase;
        sl      = ZERO_SPEED;
        sr      = ZERO_SPEED;
        if (n_mode == MODE_AUTO) begin
            if (r_in.front_obstacle) begin
                n_mode = MODE_OBSTACLE;
            end else if (!r_in.line_lost) begin
                sl = steer_l;
                sr = steer_r;
            end
        end
        if (n_mode == MODE_MANUAL && r_in.command == CMD_ANGLE) begin
            sl = steer_l;
            sr = steer_r;
        end
        if (n_mode == MODE_OBSTACLE) begin
            case (r_phase)
                PH_ROTATE: begin
                    sl = HALF_SPEED;
                    sr = -HALF_SPEED;
                    if (r_in.left_obstacle) begin
                        n_phase = PH_FORWARD;
                    end
                end
                PH_FORWARD, PH_TURN: begin
                    sl = (r_phase == PH_FORWARD) ? HALF_SPEED : ZERO_SPEED;
                    sr = HALF_SPEED;
                    if (!r_in.line_lost &&
                        (r_in.line_position < i_cfg.rejoin_threshold)) begin
                        n_phase = PH_ROTATE;
                        n_mode  = MODE_AUTO;
                    end else if (r_left && !r_in.left_obstacle) begin
                        n_phase = (r_phase == PH_FORWARD) ? PH_TURN : PH_FORWARD;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_AUTO;
            r_phase     <= PH_ROTATE;
            r_left      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.do_fin) begin
                r_mode      <= n_mode;
                r_phase     <= n_phase;
                r_rsp_valid <= 1'b1;
                // obstacle logic ran this tick, even if it rejoined the line
                if ((mode_pre == MODE_OBSTACLE) ||
                    (mode_pre == MODE_AUTO && r_in.front_obstacle)) begin
                    r_left <= r_in.left_obstacle;
                end
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_fin) begin
            r_rsp.speed_left  <= sl;
            r_rsp.speed_right <= sr;
            r_rsp.mode_now    <= n_mode;
        end
    end

    assign o_sts.out_busy = r_rsp_valid && !i_rsp_ready;
    assign o_rsp_valid    = r_rsp_valid;
    assign o_rsp          = r_rsp;

endmodule

/* src/line_follow_pilot_fsm.sv */
`timescale 1ns / 1ps
// Channel    | Direction | Handshake                   | Payload
// request    | in        | i_req_valid / o_req_ready   | i_req  (lfp_pkg::t_req)
// response   | out       | o_rsp_valid / i_rsp_ready   | o_rsp  (lfp_pkg::t_rsp)
// config     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One request runs through the steps accept, square, two passes of the shared
// 31x16 multiplier for the two curves, then decide. The result is registered
// in the decide step; the next request is taken only once the previous one
// has left the decide step. One request is in work at a time.
// Reset (i_rst_n low, synchronous) puts the pilot in autonomous mode,
// phase 0, and loads the default curve gains and rejoin threshold.
// The output register frees the core: a new request is taken while a
// result waits; the decide step stalls only if that register is still full.
// Config writes are always ready; indexes past the last register are dropped.

module line_follow_pilot_fsm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  lfp_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output lfp_pkg::t_rsp  o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data
);
    import lfp_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.curve_gain       <= GAIN_RST;
            r_cfg.curve_gain_recip <= RECIP_RST;
            r_cfg.rejoin_threshold <= REJOIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN:   r_cfg.curve_gain       <= i_cfg_data;
                CFG_RECIP:  r_cfg.curve_gain_recip <= i_cfg_data;
                CFG_REJOIN: r_cfg.rejoin_threshold <= $signed(i_cfg_data);
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    lfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    lfp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_cfg       (r_cfg),
        .i_req       (i_req),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

/* src/lfp_checker.sv */
`timescale 1ns / 1ps

module lfp_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           o_req_ready,
    input  lfp_pkg::t_req  i_req,
    input  logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  lfp_pkg::t_rsp  o_rsp
);
    import lfp_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // waiting request holds
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_ready |=> i_req_valid && $stable(i_req))
        else $error("request changed while waiting");

    // one request in work at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while busy");

    // shock mode drives both wheels to zero
    a_shock_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.mode_now == MODE_SHOCK |->
            o_rsp.speed_left == 16'sd0 && o_rsp.speed_right == 16'sd0)
        else $error("wheels moving in shock mode");

    // obstacle avoidance uses half speed on the right wheel
    a_obst_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.mode_now == MODE_OBSTACLE |->
            o_rsp.speed_right == HALF_SPEED || o_rsp.speed_right == -HALF_SPEED)
        else $error("bad right speed in obstacle mode");

endmodule

bind line_follow_pilot_fsm lfp_checker u_lfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
